// File: design/json_stream_tokenizer_macros.svh
// Assertion macros used by the tokenizer queue RTL.
// Depends on nothing; empty when SYNTHESIS is defined.
`ifndef JSON_STREAM_TOKENIZER_MACROS_SVH
`define JSON_STREAM_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define JST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define JST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define JST_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define JST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/jst_pkg.sv
// Types, codes and helper functions of the JSON stream tokenizer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package jst_pkg;
	typedef enum logic [4:0] {
		M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_AFTER,
		M_LIT0, M_LIT1, M_LIT2, M_STR, M_ESC, M_HEX, M_HI, M_HI_BS, M_LOW,
		M_SIGN, M_ZERO, M_INT, M_DOT, M_FRAC, M_E, M_ESIGN, M_EXP
	} mode_t;

	localparam logic [3:0] EV_OBJ_BEGIN = 4'd0;
	localparam logic [3:0] EV_OBJ_END   = 4'd1;
	localparam logic [3:0] EV_ARR_BEGIN = 4'd2;
	localparam logic [3:0] EV_ARR_END   = 4'd3;
	localparam logic [3:0] EV_KEY_BEGIN = 4'd4;
	localparam logic [3:0] EV_KEY_END   = 4'd5;
	localparam logic [3:0] EV_STR_BEGIN = 4'd6;
	localparam logic [3:0] EV_STR_END   = 4'd7;
	localparam logic [3:0] EV_STR_BYTE  = 4'd8;
	localparam logic [3:0] EV_NULL      = 4'd9;
	localparam logic [3:0] EV_TRUE      = 4'd10;
	localparam logic [3:0] EV_FALSE     = 4'd11;
	localparam logic [3:0] EV_NUM_CHAR  = 4'd12;
	localparam logic [3:0] EV_NUM_END   = 4'd13;
	localparam logic [3:0] EV_OK        = 4'd14;
	localparam logic [3:0] EV_ERROR     = 4'd15;

	localparam logic [4:0] ERR_NONE       = 5'd0;
	localparam logic [4:0] ERR_TRAILING   = 5'd1;
	localparam logic [4:0] ERR_UNEXP_END  = 5'd2;
	localparam logic [4:0] ERR_LITERAL    = 5'd3;
	localparam logic [4:0] ERR_CTRL_CHAR  = 5'd4;
	localparam logic [4:0] ERR_UNTERM_ESC = 5'd5;
	localparam logic [4:0] ERR_SHORT_UNI  = 5'd6;
	localparam logic [4:0] ERR_BAD_UNI    = 5'd7;
	localparam logic [4:0] ERR_BAD_LOW    = 5'd8;
	localparam logic [4:0] ERR_BAD_ESC    = 5'd9;
	localparam logic [4:0] ERR_UNTERM_STR = 5'd10;
	localparam logic [4:0] ERR_NUMBER     = 5'd11;
	localparam logic [4:0] ERR_FRACTION   = 5'd12;
	localparam logic [4:0] ERR_EXPONENT   = 5'd13;
	localparam logic [4:0] ERR_TOO_DEEP   = 5'd14;
	localparam logic [4:0] ERR_UNTERM_ARR = 5'd15;
	localparam logic [4:0] ERR_ARR_COMMA  = 5'd16;
	localparam logic [4:0] ERR_KEY_EXP    = 5'd17;
	localparam logic [4:0] ERR_COLON_EXP  = 5'd18;
	localparam logic [4:0] ERR_UNTERM_OBJ = 5'd19;
	localparam logic [4:0] ERR_OBJ_COMMA  = 5'd20;

	localparam int MaxRes = 4;

	typedef struct packed {
		logic [3:0] ev;
		logic [7:0] pl;
		logic [4:0] code;
		logic [6:0] depth;
	} res_t;

	typedef struct packed {
		res_t [MaxRes-1:0] r;
		logic [2:0]        n;
	} bundle_t;

	function automatic bundle_t add_res(bundle_t b, logic [3:0] ev, logic [7:0] pl,
			logic [4:0] cd, logic [6:0] dep);
		if (b.n < 3'(MaxRes)) begin
			b.r[b.n[1:0]] = '{ev: ev, pl: pl, code: cd, depth: dep};
			b.n = b.n + 3'd1;
		end
		return b;
	endfunction

	function automatic bundle_t add_final(bundle_t b, logic [3:0] ev, logic [4:0] cd,
			logic [6:0] dep);
		if (b.n >= 3'(MaxRes)) b.n = 3'(MaxRes - 1);
		return add_res(b, ev, 8'h00, cd, dep);
	endfunction

	function automatic bundle_t add_cp(bundle_t b, logic [20:0] cp, logic [6:0] dep);
		if (cp <= 21'h7F) begin
			b = add_res(b, EV_STR_BYTE, cp[7:0], ERR_NONE, dep);
		end else if (cp <= 21'h7FF) begin
			b = add_res(b, EV_STR_BYTE, 8'hC0 | {3'b000, cp[10:6]}, ERR_NONE, dep);
			b = add_res(b, EV_STR_BYTE, 8'h80 | {2'b00, cp[5:0]}, ERR_NONE, dep);
		end else if (cp <= 21'hFFFF) begin
			b = add_res(b, EV_STR_BYTE, 8'hE0 | {4'h0, cp[15:12]}, ERR_NONE, dep);
			b = add_res(b, EV_STR_BYTE, 8'h80 | {2'b00, cp[11:6]}, ERR_NONE, dep);
			b = add_res(b, EV_STR_BYTE, 8'h80 | {2'b00, cp[5:0]}, ERR_NONE, dep);
		end else begin
			b = add_res(b, EV_STR_BYTE, 8'hF0 | {5'b00000, cp[20:18]}, ERR_NONE, dep);
			b = add_res(b, EV_STR_BYTE, 8'h80 | {2'b00, cp[17:12]}, ERR_NONE, dep);
			b = add_res(b, EV_STR_BYTE, 8'h80 | {2'b00, cp[11:6]}, ERR_NONE, dep);
			b = add_res(b, EV_STR_BYTE, 8'h80 | {2'b00, cp[5:0]}, ERR_NONE, dep);
		end
		return b;
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// bit 4 flags a valid hex digit
	function automatic logic [4:0] hex_value(logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (is_digit(c)) begin
			d = c - 8'h30;
			return {1'b1, d[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b1, d[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b1, d[3:0]};
		end
		return 5'h00;
	endfunction

	function automatic logic [7:0] lit_ch(logic [1:0] k, logic [2:0] p);
		logic [7:0] ch;
		ch = 8'h00;
		case (k)
			2'd0: case (p)
				3'd0: ch = 8'h6E; 3'd1: ch = 8'h75; 3'd2: ch = 8'h6C; 3'd3: ch = 8'h6C;
				default: ch = 8'h00;
			endcase
			2'd1: case (p)
				3'd0: ch = 8'h74; 3'd1: ch = 8'h72; 3'd2: ch = 8'h75; 3'd3: ch = 8'h65;
				default: ch = 8'h00;
			endcase
			default: case (p)
				3'd0: ch = 8'h66; 3'd1: ch = 8'h61; 3'd2: ch = 8'h6C; 3'd3: ch = 8'h73;
				3'd4: ch = 8'h65;
				default: ch = 8'h00;
			endcase
		endcase
		return ch;
	endfunction
endpackage
`default_nettype wire

// File: design/jst_if.sv
// Valid/ready channel interfaces for tokenizer input bytes and result events.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface jst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_input;
	modport source (output valid, data_byte, has_byte, end_of_input, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_input, output ready);
endinterface

interface jst_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_res;
	logic [7:0] payload_byte;
	logic [4:0] error_code;
	logic [6:0] nest_depth;
	logic       last;
	modport source (output valid, event_res, payload_byte, error_code, nest_depth, last,
		input ready);
	modport sink (input valid, event_res, payload_byte, error_code, nest_depth, last,
		output ready);
endinterface
`default_nettype wire

// File: design/jst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module jst_ram #(
	parameter int Width = 1,
	parameter int Depth = 64,
	parameter int AddrW = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: design/jst_front.sv
// Front end: accepts bytes, runs the grammar state and nesting stack, and
// builds one bundle of up to four results per transaction. Depends on jst_pkg, jst_ram.
`timescale 1ns / 1ps
`default_nettype none
module jst_front #(
	parameter int MAX_DEPTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [7:0]       in_byte,
	input  wire logic             in_has,
	input  wire logic             in_end,
	input  wire logic             q_full,
	output logic                  in_ready,
	output logic                  q_push,
	output jst_pkg::bundle_t      q_data
);
	localparam int LW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	typedef struct packed {
		jst_pkg::mode_t   m;
		logic [LW-1:0]    l;
		logic [2:0]       lp;
		logic [15:0]      ha;
		logic [2:0]       hc;
		logic [9:0]       ph;
		logic             ik;
		logic             er;
		logic             tk;
		logic             psh;
		logic             pop;
		logic             ext;
		jst_pkg::bundle_t b;
	} st_t;

	jst_pkg::mode_t m_q;
	logic [LW-1:0]  l_q;
	logic [2:0]     lp_q;
	logic [15:0]    ha_q;
	logic [2:0]     hc_q;
	logic [9:0]     ph_q;
	logic           ik_q;
	logic           er_q;
	logic           top_q;
	logic           byp_q;
	logic           byp_sel_q;
	logic           below_v;
	logic           ram_rd;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [AW-1:0]  ram_raddr;
	logic           take;
	logic [LW-1:0]  l_next;
	st_t            s;

	function automatic st_t f_emit(st_t x, logic [3:0] ev, logic [7:0] pl, logic [4:0] cd);
		x.b = jst_pkg::add_res(x.b, ev, pl, cd, 7'(x.l));
		return x;
	endfunction

	function automatic st_t f_fail(st_t x, logic [4:0] cd);
		x = f_emit(x, jst_pkg::EV_ERROR, 8'h00, cd);
		x.er = 1'b1;
		return x;
	endfunction

	function automatic st_t f_open(st_t x, logic k);
		if (x.l >= LW'(MAX_DEPTH)) return f_fail(x, jst_pkg::ERR_TOO_DEEP);
		x.psh = 1'b1;
		x.l = x.l + 1'b1;
		x.tk = k;
		x = f_emit(x, k ? jst_pkg::EV_OBJ_BEGIN : jst_pkg::EV_ARR_BEGIN, 8'h00,
			jst_pkg::ERR_NONE);
		x.m = k ? jst_pkg::M_OBJ_FIRST : jst_pkg::M_ARR_FIRST;
		return x;
	endfunction

	function automatic st_t f_close(st_t x, logic k, logic below);
		if (x.l != '0) begin
			x.l = x.l - 1'b1;
			x.pop = 1'b1;
			x.tk = below;
		end
		x = f_emit(x, k ? jst_pkg::EV_OBJ_END : jst_pkg::EV_ARR_END, 8'h00, jst_pkg::ERR_NONE);
		x.m = jst_pkg::M_AFTER;
		return x;
	endfunction

	function automatic st_t f_value(st_t x, logic [7:0] c);
		case (c)
			8'h6E: begin x.m = jst_pkg::M_LIT0; x.lp = 3'd1; end
			8'h74: begin x.m = jst_pkg::M_LIT1; x.lp = 3'd1; end
			8'h66: begin x.m = jst_pkg::M_LIT2; x.lp = 3'd1; end
			8'h22: begin
				x = f_emit(x, jst_pkg::EV_STR_BEGIN, 8'h00, jst_pkg::ERR_NONE);
				x.ik = 1'b0;
				x.m = jst_pkg::M_STR;
			end
			8'h5B: x = f_open(x, 1'b0);
			8'h7B: x = f_open(x, 1'b1);
			8'h2D: begin
				x = f_emit(x, jst_pkg::EV_NUM_CHAR, c, jst_pkg::ERR_NONE);
				x.m = jst_pkg::M_SIGN;
			end
			8'h30: begin
				x = f_emit(x, jst_pkg::EV_NUM_CHAR, c, jst_pkg::ERR_NONE);
				x.m = jst_pkg::M_ZERO;
			end
			default: begin
				if (c inside {[8'h31:8'h39]}) begin
					x = f_emit(x, jst_pkg::EV_NUM_CHAR, c, jst_pkg::ERR_NONE);
					x.m = jst_pkg::M_INT;
				end else begin
					x = f_fail(x, jst_pkg::ERR_NUMBER);
				end
			end
		endcase
		return x;
	endfunction

	function automatic st_t f_str(st_t x, logic [7:0] c);
		if (c == 8'h22) begin
			if (x.ik) begin
				x = f_emit(x, jst_pkg::EV_KEY_END, 8'h00, jst_pkg::ERR_NONE);
				x.ik = 1'b0;
				x.m = jst_pkg::M_COLON;
			end else begin
				x = f_emit(x, jst_pkg::EV_STR_END, 8'h00, jst_pkg::ERR_NONE);
				x.m = jst_pkg::M_AFTER;
			end
		end else if (c < 8'h20) begin
			x = f_fail(x, jst_pkg::ERR_CTRL_CHAR);
		end else if (c == 8'h5C) begin
			x.m = jst_pkg::M_ESC;
		end else begin
			x = f_emit(x, jst_pkg::EV_STR_BYTE, c, jst_pkg::ERR_NONE);
		end
		return x;
	endfunction

	function automatic st_t f_esc(st_t x, logic [7:0] c);
		logic [7:0] v;
		logic       ok;
		v = c;
		ok = 1'b1;
		case (c)
			8'h22, 8'h5C, 8'h2F: v = c;
			8'h62: v = 8'h08;
			8'h66: v = 8'h0C;
			8'h6E: v = 8'h0A;
			8'h72: v = 8'h0D;
			8'h74: v = 8'h09;
			8'h75: begin
				x.ha = 16'h0000;
				x.hc = 3'd0;
				x.m = jst_pkg::M_HEX;
				return x;
			end
			default: ok = 1'b0;
		endcase
		if (!ok) return f_fail(x, jst_pkg::ERR_BAD_ESC);
		x = f_emit(x, jst_pkg::EV_STR_BYTE, v, jst_pkg::ERR_NONE);
		x.m = jst_pkg::M_STR;
		return x;
	endfunction

	function automatic st_t f_flush(st_t x);
		x.b = jst_pkg::add_cp(x.b, 21'hD800 + {11'h000, x.ph}, 7'(x.l));
		x.ph = 10'h000;
		return x;
	endfunction

	function automatic st_t f_num(st_t x, logic [7:0] c);
		logic dig;
		dig = jst_pkg::is_digit(c);
		x.ext = 1'b1;
		case (x.m)
			jst_pkg::M_SIGN: begin
				if (c == 8'h30) x.m = jst_pkg::M_ZERO;
				else if (c inside {[8'h31:8'h39]}) x.m = jst_pkg::M_INT;
				else return f_fail(x, jst_pkg::ERR_NUMBER);
			end
			jst_pkg::M_ZERO, jst_pkg::M_INT, jst_pkg::M_FRAC: begin
				if (!(dig && x.m != jst_pkg::M_ZERO)) begin
					if (c == 8'h2E && x.m != jst_pkg::M_FRAC) x.m = jst_pkg::M_DOT;
					else if (c == 8'h65 || c == 8'h45) x.m = jst_pkg::M_E;
					else begin
						x.ext = 1'b0;
						return x;
					end
				end
			end
			jst_pkg::M_DOT: begin
				if (dig) x.m = jst_pkg::M_FRAC;
				else return f_fail(x, jst_pkg::ERR_FRACTION);
			end
			jst_pkg::M_E: begin
				if (c == 8'h2B || c == 8'h2D) x.m = jst_pkg::M_ESIGN;
				else if (dig) x.m = jst_pkg::M_EXP;
				else return f_fail(x, jst_pkg::ERR_EXPONENT);
			end
			jst_pkg::M_ESIGN: begin
				if (dig) x.m = jst_pkg::M_EXP;
				else return f_fail(x, jst_pkg::ERR_EXPONENT);
			end
			default: begin
				if (!dig) begin
					x.ext = 1'b0;
					return x;
				end
			end
		endcase
		return f_emit(x, jst_pkg::EV_NUM_CHAR, c, jst_pkg::ERR_NONE);
	endfunction

	function automatic st_t f_hex(st_t x, logic [7:0] c, logic low);
		logic [4:0] d;
		d = jst_pkg::hex_value(c);
		if (!d[4]) return f_fail(x, low ? jst_pkg::ERR_BAD_LOW : jst_pkg::ERR_BAD_UNI);
		x.ha = {x.ha[11:0], d[3:0]};
		x.hc = x.hc + 3'd1;
		if (x.hc < 3'd4) return x;
		x.hc = 3'd0;
		if (!low) begin
			if (x.ha >= 16'hD800 && x.ha <= 16'hDBFF) begin
				x.ph = x.ha[9:0];
				x.m = jst_pkg::M_HI;
			end else begin
				x.b = jst_pkg::add_cp(x.b, {5'h00, x.ha}, 7'(x.l));
				x.m = jst_pkg::M_STR;
			end
		end else begin
			if (x.ha < 16'hDC00 || x.ha > 16'hDFFF) return f_fail(x, jst_pkg::ERR_BAD_LOW);
			x.b = jst_pkg::add_cp(x.b, 21'h10000 + {1'b0, x.ph, 10'h000} +
				{11'h000, x.ha[9:0]}, 7'(x.l));
			x.ph = 10'h000;
			x.m = jst_pkg::M_STR;
		end
		x.ha = 16'h0000;
		return x;
	endfunction

	function automatic st_t f_lit(st_t x, logic [7:0] c, logic [1:0] k);
		if (x.lp < 3'd5 && c == jst_pkg::lit_ch(k, x.lp)) begin
			x.lp = x.lp + 3'd1;
			if (x.lp >= ((k == 2'd2) ? 3'd5 : 3'd4)) begin
				x.lp = 3'd0;
				x = f_emit(x, jst_pkg::EV_NULL + {2'b00, k}, 8'h00, jst_pkg::ERR_NONE);
				x.m = jst_pkg::M_AFTER;
			end
			return x;
		end
		return f_fail(x, jst_pkg::ERR_LITERAL);
	endfunction

	function automatic st_t f_byte(st_t x, logic [7:0] c, logic below);
		logic ws;
		ws = jst_pkg::is_ws(c);
		if (x.m inside {jst_pkg::M_SIGN, jst_pkg::M_ZERO, jst_pkg::M_INT, jst_pkg::M_DOT,
				jst_pkg::M_FRAC, jst_pkg::M_E, jst_pkg::M_ESIGN, jst_pkg::M_EXP}) begin
			x = f_num(x, c);
			if (x.ext) return x;
			x = f_emit(x, jst_pkg::EV_NUM_END, 8'h00, jst_pkg::ERR_NONE);
			x.m = jst_pkg::M_AFTER;
		end
		case (x.m)
			jst_pkg::M_VALUE: if (!ws) x = f_value(x, c);
			jst_pkg::M_ARR_FIRST: begin
				if (!ws) begin
					if (c == 8'h5D) x = f_close(x, 1'b0, below);
					else x = f_value(x, c);
				end
			end
			jst_pkg::M_OBJ_FIRST, jst_pkg::M_OBJ_KEY: begin
				if (!ws) begin
					if (c == 8'h7D && x.m == jst_pkg::M_OBJ_FIRST) begin
						x = f_close(x, 1'b1, below);
					end else if (c == 8'h22) begin
						x = f_emit(x, jst_pkg::EV_KEY_BEGIN, 8'h00, jst_pkg::ERR_NONE);
						x.ik = 1'b1;
						x.m = jst_pkg::M_STR;
					end else begin
						x = f_fail(x, jst_pkg::ERR_KEY_EXP);
					end
				end
			end
			jst_pkg::M_COLON: begin
				if (!ws) begin
					if (c == 8'h3A) x.m = jst_pkg::M_VALUE;
					else x = f_fail(x, jst_pkg::ERR_COLON_EXP);
				end
			end
			jst_pkg::M_AFTER: begin
				if (!ws) begin
					if (x.l == '0) x = f_fail(x, jst_pkg::ERR_TRAILING);
					else if (!x.tk) begin
						if (c == 8'h5D) x = f_close(x, 1'b0, below);
						else if (c == 8'h2C) x.m = jst_pkg::M_VALUE;
						else x = f_fail(x, jst_pkg::ERR_ARR_COMMA);
					end else begin
						if (c == 8'h7D) x = f_close(x, 1'b1, below);
						else if (c == 8'h2C) x.m = jst_pkg::M_OBJ_KEY;
						else x = f_fail(x, jst_pkg::ERR_OBJ_COMMA);
					end
				end
			end
			jst_pkg::M_LIT0: x = f_lit(x, c, 2'd0);
			jst_pkg::M_LIT1: x = f_lit(x, c, 2'd1);
			jst_pkg::M_LIT2: x = f_lit(x, c, 2'd2);
			jst_pkg::M_STR: x = f_str(x, c);
			jst_pkg::M_ESC: x = f_esc(x, c);
			jst_pkg::M_HEX: x = f_hex(x, c, 1'b0);
			jst_pkg::M_LOW: x = f_hex(x, c, 1'b1);
			jst_pkg::M_HI: begin
				if (c == 8'h5C) x.m = jst_pkg::M_HI_BS;
				else begin
					x = f_flush(x);
					x.m = jst_pkg::M_STR;
					x = f_str(x, c);
				end
			end
			jst_pkg::M_HI_BS: begin
				if (c == 8'h75) begin
					x.ha = 16'h0000;
					x.hc = 3'd0;
					x.m = jst_pkg::M_LOW;
				end else begin
					x = f_flush(x);
					x = f_esc(x, c);
				end
			end
			default: x = f_fail(x, jst_pkg::ERR_NUMBER);
		endcase
		return x;
	endfunction

	function automatic st_t f_end(st_t x);
		logic [4:0] cd;
		cd = jst_pkg::ERR_NONE;
		if (x.er) return x;
		if (x.m inside {jst_pkg::M_ZERO, jst_pkg::M_INT, jst_pkg::M_FRAC, jst_pkg::M_EXP}) begin
			x = f_emit(x, jst_pkg::EV_NUM_END, 8'h00, jst_pkg::ERR_NONE);
			x.m = jst_pkg::M_AFTER;
		end
		case (x.m)
			jst_pkg::M_VALUE, jst_pkg::M_ARR_FIRST: cd = jst_pkg::ERR_UNEXP_END;
			jst_pkg::M_OBJ_FIRST, jst_pkg::M_OBJ_KEY: cd = jst_pkg::ERR_KEY_EXP;
			jst_pkg::M_COLON: cd = jst_pkg::ERR_COLON_EXP;
			jst_pkg::M_AFTER: begin
				if (x.l != '0) cd = x.tk ? jst_pkg::ERR_UNTERM_OBJ : jst_pkg::ERR_UNTERM_ARR;
			end
			jst_pkg::M_LIT0, jst_pkg::M_LIT1, jst_pkg::M_LIT2: cd = jst_pkg::ERR_LITERAL;
			jst_pkg::M_STR: cd = jst_pkg::ERR_UNTERM_STR;
			jst_pkg::M_ESC: cd = jst_pkg::ERR_UNTERM_ESC;
			jst_pkg::M_HEX, jst_pkg::M_LOW: cd = jst_pkg::ERR_SHORT_UNI;
			jst_pkg::M_HI: begin
				x = f_flush(x);
				cd = jst_pkg::ERR_UNTERM_STR;
			end
			jst_pkg::M_HI_BS: begin
				x = f_flush(x);
				cd = jst_pkg::ERR_UNTERM_ESC;
			end
			jst_pkg::M_SIGN: cd = jst_pkg::ERR_NUMBER;
			jst_pkg::M_DOT: cd = jst_pkg::ERR_FRACTION;
			default: cd = jst_pkg::ERR_EXPONENT;
		endcase
		if (cd == jst_pkg::ERR_NONE)
			x.b = jst_pkg::add_final(x.b, jst_pkg::EV_OK, jst_pkg::ERR_NONE, 7'(x.l));
		else
			x.b = jst_pkg::add_final(x.b, jst_pkg::EV_ERROR, cd, 7'(x.l));
		return x;
	endfunction

	assign below_v = byp_sel_q ? byp_q : ram_rd;
	assign in_ready = !q_full;
	assign take = in_valid && in_ready;

	always_comb begin
		s = '{m: m_q, l: l_q, lp: lp_q, ha: ha_q, hc: hc_q, ph: ph_q, ik: ik_q, er: er_q,
			tk: top_q, psh: 1'b0, pop: 1'b0, ext: 1'b0, b: '0};
		if (in_has && !er_q) s = f_byte(s, in_byte, below_v);
		if (in_end) s = f_end(s);
	end

	assign q_push = take && (s.b.n != 3'd0);
	assign q_data = s.b;
	assign l_next = take ? (in_end ? '0 : s.l) : l_q;
	assign ram_we = take && s.psh && (l_q != '0);
	assign ram_waddr = AW'(l_q - 1'b1);
	assign ram_raddr = (l_next >= LW'(2)) ? AW'(l_next - LW'(2)) : '0;

	jst_ram #(.Width(1), .Depth(MAX_DEPTH), .AddrW(AW)) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (top_q),
		.raddr (ram_raddr),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= jst_pkg::M_VALUE;
			l_q <= '0;
			lp_q <= 3'd0;
			ha_q <= 16'h0000;
			hc_q <= 3'd0;
			ph_q <= 10'h000;
			ik_q <= 1'b0;
			er_q <= 1'b0;
			top_q <= 1'b0;
			byp_sel_q <= 1'b0;
			byp_q <= 1'b0;
		end else begin
			byp_sel_q <= 1'b0;
			if (take) begin
				byp_sel_q <= s.psh;
				byp_q <= top_q;
				if (in_end) begin
					m_q <= jst_pkg::M_VALUE;
					l_q <= '0;
					lp_q <= 3'd0;
					ha_q <= 16'h0000;
					hc_q <= 3'd0;
					ph_q <= 10'h000;
					ik_q <= 1'b0;
					er_q <= 1'b0;
					top_q <= 1'b0;
				end else begin
					m_q <= s.m;
					l_q <= s.l;
					lp_q <= s.lp;
					ha_q <= s.ha;
					hc_q <= s.hc;
					ph_q <= s.ph;
					ik_q <= s.ik;
					er_q <= s.er;
					top_q <= s.tk;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: design/jst_queue.sv
// Short bundle queue between front and back end.
// Depends on jst_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "json_stream_tokenizer_macros.svh"
module jst_queue #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire jst_pkg::bundle_t wdata,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output jst_pkg::bundle_t      rdata
);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	jst_pkg::bundle_t slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full = cnt_q == CW'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`JST_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !full)
	`JST_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, !empty)
	`JST_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1)
	`JST_ASSERT_NOW(a_nonempty_bundle, clk, arst_n, !empty, rdata.n != 3'd0)
endmodule
`default_nettype wire

// File: design/jst_back.sv
// Back end: sends the results of the head bundle one transaction at a time.
// Depends on jst_pkg and jst_if.
`timescale 1ns / 1ps
`default_nettype none
module jst_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             empty,
	input  wire jst_pkg::bundle_t head,
	output logic                  pop,
	jst_out_if.source             out_ch
);
	logic [1:0]    idx_q;
	logic          is_last;
	jst_pkg::res_t cur;

	assign cur = head.r[idx_q];
	assign is_last = {1'b0, idx_q} == head.n - 3'd1;
	assign out_ch.valid = !empty;
	assign out_ch.event_res = cur.ev;
	assign out_ch.payload_byte = cur.pl;
	assign out_ch.error_code = cur.code;
	assign out_ch.nest_depth = cur.depth;
	assign out_ch.last = is_last;
	assign pop = out_ch.valid && out_ch.ready && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (out_ch.valid && out_ch.ready) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end
endmodule
`default_nettype wire

// File: design/json_stream_tokenizer.sv
// Results: a result is offered once its bundle is registered in the queue and reaches its head.
// Throughput: one input byte per cycle while the queue is not full; results leave one per cycle
// while the output is ready, each result taking its own transfer, with a four-bundle queue absorbing bursts.
// Reset: asynchronous, active low; clears grammar state, depth and queue. Stack contents
// stay undefined until pushed.
`timescale 1ns / 1ps
`default_nettype none
module json_stream_tokenizer #(
	parameter int MAX_DEPTH = 64,
	parameter int QUEUE_DEPTH = 4
) (
	input wire logic  clk,
	input wire logic  arst_n,
	jst_in_if.sink    in_ch,
	jst_out_if.source out_ch
);
	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	jst_pkg::bundle_t q_wdata;
	jst_pkg::bundle_t q_rdata;

	jst_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_byte  (in_ch.data_byte),
		.in_has   (in_ch.has_byte),
		.in_end   (in_ch.end_of_input),
		.q_full   (q_full),
		.in_ready (in_ch.ready),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	jst_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	jst_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (q_rdata),
		.pop    (q_pop),
		.out_ch (out_ch)
	);
endmodule
`default_nettype wire
